@@ rtl/dkat_pkg.sv @@
// Shared types and constants of the dual-key address translation table.
package dkat_pkg;

  // Default sizes of the table
  localparam int unsigned ROWS_DEFAULT        = 32;
  localparam int unsigned ADDR_BITS_DEFAULT   = 48;
  localparam int unsigned SECURE_BITS_DEFAULT = 64;
  localparam int unsigned ID_BITS_DEFAULT     = 64;

  // Fixed port widths
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned SECURE_W    = 64;
  localparam int unsigned ID_W        = 64;
  localparam int unsigned ROW_INDEX_W = 5;

  // Entries of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Command codes
  typedef enum logic [1:0] {
    CMD_REGISTER    = 2'd0,
    CMD_UNREGISTER  = 2'd1,
    CMD_LOOKUP_ADDR = 2'd2,
    CMD_LOOKUP_SEC  = 2'd3
  } cmd_e;

  // Search controls derived from the command
  typedef struct packed {
    logic match_addr;  // compare row address with the address key
    logic match_sec;   // compare row secure key with the secure key
    logic need_valid;  // only valid rows take part
    logic take_free;   // fall back to the first invalid row
  } class_t;

  // One queued command
  typedef struct packed {
    cmd_e                  cmd;
    class_t                cls;
    logic [ADDR_W-1:0]     address_key;
    logic [SECURE_W-1:0]   secure_key;
    logic [ID_W-1:0]       identifier;
  } item_t;

endpackage

@@ rtl/dkat_front.sv @@
// Front end: accepts commands, classifies them and queues them for the table.
module dkat_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    cmd_i,
  input  logic [dkat_pkg::ADDR_W-1:0]   address_key_i,
  input  logic [dkat_pkg::SECURE_W-1:0] secure_key_i,
  input  logic [dkat_pkg::ID_W-1:0]     identifier_in_i,
  input  logic                          pop_i,
  output logic                          not_empty_o,
  output dkat_pkg::item_t               head_o
);
  import dkat_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            queue_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  logic             pop;
  item_t            item_in;

  // Classify the incoming command
  always_comb begin
    item_in.cmd         = cmd_e'(cmd_i);
    item_in.address_key = address_key_i;
    item_in.secure_key  = secure_key_i;
    item_in.identifier  = identifier_in_i;
    item_in.cls         = '0;
    case (cmd_e'(cmd_i))
      CMD_REGISTER: begin
        item_in.cls.match_addr = 1'b1;
        item_in.cls.match_sec  = 1'b1;
        item_in.cls.take_free  = 1'b1;
      end
      CMD_UNREGISTER, CMD_LOOKUP_ADDR: begin
        item_in.cls.match_addr = 1'b1;
        item_in.cls.need_valid = 1'b1;
      end
      CMD_LOOKUP_SEC: begin
        item_in.cls.match_sec  = 1'b1;
        item_in.cls.need_valid = 1'b1;
      end
      default: item_in.cls = '0;
    endcase
  end

  // Queue control
  assign busy_o      = (count_q == CntW'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign push        = start_i && !busy_o;
  assign pop         = pop_i && not_empty_o;
  assign head_o      = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

@@ rtl/dkat_back.sv @@
// Back end: row table, parallel compare, priority select, update and result.
module dkat_back #(
  parameter int unsigned ROWS        = dkat_pkg::ROWS_DEFAULT,
  parameter int unsigned ADDR_BITS   = dkat_pkg::ADDR_BITS_DEFAULT,
  parameter int unsigned SECURE_BITS = dkat_pkg::SECURE_BITS_DEFAULT,
  parameter int unsigned ID_BITS     = dkat_pkg::ID_BITS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             not_empty_i,
  input  dkat_pkg::item_t                  head_i,
  output logic                             pop_o,
  output logic                             done_o,
  output logic                             hit_o,
  output logic [dkat_pkg::ROW_INDEX_W-1:0] row_num_o,
  output logic [dkat_pkg::ADDR_W-1:0]      address_out_o,
  output logic [dkat_pkg::SECURE_W-1:0]    secure_out_o,
  output logic [dkat_pkg::ID_W-1:0]        identifier_out_o
);
  import dkat_pkg::*;

  localparam int unsigned IdxW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PadW = (IdxW > ROW_INDEX_W) ? IdxW : ROW_INDEX_W;

  // Sequencer states
  localparam logic ST_MATCH   = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  logic                   state_q, state_d;

  // Row table; a row never written reads as zero
  logic [ROWS-1:0]        row_valid_q;
  logic [ROWS-1:0]        row_init_q;
  logic [ADDR_BITS-1:0]   row_addr_q [ROWS];
  logic [SECURE_BITS-1:0] row_sec_q  [ROWS];
  logic [ID_BITS-1:0]     row_id_q   [ROWS];
  logic [ADDR_BITS-1:0]   eff_addr   [ROWS];
  logic [SECURE_BITS-1:0] eff_sec    [ROWS];
  logic [ID_BITS-1:0]     eff_id     [ROWS];

  // Compare stage
  logic [ADDR_BITS-1:0]   key_addr;
  logic [SECURE_BITS-1:0] key_sec;
  logic [ROWS-1:0]        match;
  logic [ROWS-1:0]        sel_d;

  // Registered command in resolve
  logic [ROWS-1:0]        sel_q;
  cmd_e                   cmd_q;
  logic [ADDR_BITS-1:0]   addr_q;
  logic [SECURE_BITS-1:0] sec_q;
  logic [ID_BITS-1:0]     id_q;

  // Resolve stage
  logic [IdxW-1:0]        idx;
  logic                   hit;
  logic [PadW-1:0]        idx_pad;
  logic                   write_row;
  logic                   clear_row;

  // Result registers
  logic                   done_q;
  logic                   hit_q;
  logic [ROW_INDEX_W-1:0] row_num_q;
  logic [ADDR_W-1:0]      address_out_q;
  logic [SECURE_W-1:0]    secure_out_q;
  logic [ID_W-1:0]        identifier_out_q;

  // Effective row contents
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      eff_addr[i] = row_init_q[i] ? row_addr_q[i] : '0;
      eff_sec[i]  = row_init_q[i] ? row_sec_q[i]  : '0;
      eff_id[i]   = row_init_q[i] ? row_id_q[i]   : '0;
    end
  end

  // Compare the queue head against every row
  assign key_addr = ADDR_BITS'(head_i.address_key);
  assign key_sec  = SECURE_BITS'(head_i.secure_key);

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      match[i] = ((head_i.cls.match_addr && (eff_addr[i] == key_addr)) ||
                  (head_i.cls.match_sec  && (eff_sec[i]  == key_sec))) &&
                 (!head_i.cls.need_valid || row_valid_q[i]);
    end
    if (|match) begin
      sel_d = match;
    end else if (head_i.cls.take_free) begin
      sel_d = ~row_valid_q;
    end else begin
      sel_d = '0;
    end
  end

  // Sequencer: one compare step, then one resolve step
  assign pop_o = (state_q == ST_MATCH) && not_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_MATCH:   if (not_empty_i) state_d = ST_RESOLVE;
      ST_RESOLVE: state_d = ST_MATCH;
      default:    state_d = ST_MATCH;
    endcase
  end

  // Latch the command with its selection vector
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sel_q  <= sel_d;
      cmd_q  <= head_i.cmd;
      addr_q <= key_addr;
      sec_q  <= key_sec;
      id_q   <= ID_BITS'(head_i.identifier);
    end
  end

  // Lowest selected row wins
  always_comb begin
    idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (sel_q[i]) idx = IdxW'(i);
    end
  end

  assign hit       = |sel_q;
  assign idx_pad   = PadW'(idx);
  assign write_row = (state_q == ST_RESOLVE) && hit && (cmd_q == CMD_REGISTER);
  assign clear_row = (state_q == ST_RESOLVE) && hit && (cmd_q == CMD_UNREGISTER);

  // Control state and row flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_MATCH;
      row_valid_q <= '0;
      row_init_q  <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_RESOLVE);
      if (write_row) begin
        row_valid_q[idx] <= 1'b1;
        row_init_q[idx]  <= 1'b1;
      end else if (clear_row) begin
        row_valid_q[idx] <= 1'b0;
      end
    end
  end

  // Row contents
  always_ff @(posedge clk_i) begin
    if (write_row) begin
      row_addr_q[idx] <= addr_q;
      row_sec_q[idx]  <= sec_q;
      row_id_q[idx]   <= id_q;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESOLVE) begin
      hit_q            <= hit;
      row_num_q        <= hit ? idx_pad[ROW_INDEX_W-1:0] : '0;
      address_out_q    <= (hit && (cmd_q == CMD_LOOKUP_SEC)) ? ADDR_W'(eff_addr[idx]) : '0;
      secure_out_q     <= (hit && (cmd_q == CMD_LOOKUP_ADDR)) ? SECURE_W'(eff_sec[idx]) : '0;
      identifier_out_q <= (hit && (cmd_q == CMD_LOOKUP_ADDR)) ? ID_W'(eff_id[idx]) : '0;
    end
  end

  assign done_o           = done_q;
  assign hit_o            = hit_q;
  assign row_num_o        = row_num_q;
  assign address_out_o    = address_out_q;
  assign secure_out_o     = secure_out_q;
  assign identifier_out_o = identifier_out_q;

endmodule

@@ rtl/dual_key_address_translation_table.sv @@
// Top level of the dual-key address translation table.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  command  | start_i / busy_o   | cmd_i, address_key_i, secure_key_i, identifier_in_i
//  result   | done_o (1 cycle)   | hit_o, row_num_o, address_out_o, secure_out_o,
//           |                    | identifier_out_o
//
// Each command passes the back end in a compare step, which checks the key against every
// row and picks the candidates, then a resolve step, which priority-selects the row, updates
// it and registers the result. done_o is registered behind the queue and the resolve step.
// A 2-entry queue takes commands while the back end works; busy_o is high when it is full.
// After reset all rows are invalid and read as zero; no clearing pass is needed.
// Results cannot be held off; the back end takes a new command only once it has resolved the last one.
module dual_key_address_translation_table #(
  parameter int unsigned ROWS        = dkat_pkg::ROWS_DEFAULT,
  parameter int unsigned ADDR_BITS   = dkat_pkg::ADDR_BITS_DEFAULT,
  parameter int unsigned SECURE_BITS = dkat_pkg::SECURE_BITS_DEFAULT,
  parameter int unsigned ID_BITS     = dkat_pkg::ID_BITS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       cmd_i,
  input  logic [dkat_pkg::ADDR_W-1:0]      address_key_i,
  input  logic [dkat_pkg::SECURE_W-1:0]    secure_key_i,
  input  logic [dkat_pkg::ID_W-1:0]        identifier_in_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic [dkat_pkg::ROW_INDEX_W-1:0] row_num_o,
  output logic [dkat_pkg::ADDR_W-1:0]      address_out_o,
  output logic [dkat_pkg::SECURE_W-1:0]    secure_out_o,
  output logic [dkat_pkg::ID_W-1:0]        identifier_out_o
);
  import dkat_pkg::*;

  item_t head;
  logic  not_empty;
  logic  pop;

  // Command intake and queue
  dkat_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cmd_i           (cmd_i),
    .address_key_i   (address_key_i),
    .secure_key_i    (secure_key_i),
    .identifier_in_i (identifier_in_i),
    .pop_i           (pop),
    .not_empty_o     (not_empty),
    .head_o          (head)
  );

  // Table and result
  dkat_back #(
    .ROWS        (ROWS),
    .ADDR_BITS   (ADDR_BITS),
    .SECURE_BITS (SECURE_BITS),
    .ID_BITS     (ID_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .not_empty_i      (not_empty),
    .head_i           (head),
    .pop_o            (pop),
    .done_o           (done_o),
    .hit_o            (hit_o),
    .row_num_o        (row_num_o),
    .address_out_o    (address_out_o),
    .secure_out_o     (secure_out_o),
    .identifier_out_o (identifier_out_o)
  );

endmodule

@@ rtl/dkat_checker.sv @@
// Port-level checks of the translation table, bound to the top level.
module dkat_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             done_o,
  input logic                             hit_o,
  input logic [dkat_pkg::ROW_INDEX_W-1:0] row_num_o,
  input logic [dkat_pkg::ADDR_W-1:0]      address_out_o,
  input logic [dkat_pkg::SECURE_W-1:0]    secure_out_o,
  input logic [dkat_pkg::ID_W-1:0]        identifier_out_o
);

  // Two-step back end: results never come in adjacent cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("results in adjacent cycles");

  // A miss carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (row_num_o == '0 && address_out_o == '0 &&
                            secure_out_o == '0 && identifier_out_o == '0))
    else $error("miss with nonzero payload");

  // Only one lookup direction fills data fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (address_out_o == '0 || (secure_out_o == '0 && identifier_out_o == '0)))
    else $error("both lookup directions in one result");

  // The queue only fills up after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a transfer");

endmodule

bind dual_key_address_translation_table dkat_checker u_checker (.*);

@@ dv/dual_key_address_translation_table_checker.sv @@
// Checker for the translation table: tracks accepted commands, predicts results, compares.
module dual_key_address_translation_table_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [1:0]                       cmd_i,
  input  logic [dkat_pkg::ADDR_W-1:0]      address_key_i,
  input  logic [dkat_pkg::SECURE_W-1:0]    secure_key_i,
  input  logic [dkat_pkg::ID_W-1:0]        identifier_in_i,
  input  logic                             done_i,
  input  logic                             hit_i,
  input  logic [dkat_pkg::ROW_INDEX_W-1:0] row_num_i,
  input  logic [dkat_pkg::ADDR_W-1:0]      address_out_i,
  input  logic [dkat_pkg::SECURE_W-1:0]    secure_out_i,
  input  logic [dkat_pkg::ID_W-1:0]        identifier_out_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dkat_pkg::*;

  localparam int unsigned ROWS        = ROWS_DEFAULT;
  localparam int unsigned ADDR_BITS   = ADDR_BITS_DEFAULT;
  localparam int unsigned SECURE_BITS = SECURE_BITS_DEFAULT;
  localparam int unsigned ID_BITS     = ID_BITS_DEFAULT;

  localparam logic [ADDR_W-1:0]   ADDR_MASK   = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_BITS);
  localparam logic [SECURE_W-1:0] SECURE_MASK = {SECURE_W{1'b1}} >> (SECURE_W - SECURE_BITS);
  localparam logic [ID_W-1:0]     ID_MASK     = {ID_W{1'b1}} >> (ID_W - ID_BITS);

  typedef struct packed {
    logic                   hit;
    logic [ROW_INDEX_W-1:0] row_num;
    logic [ADDR_W-1:0]      address;
    logic [SECURE_W-1:0]    secure;
    logic [ID_W-1:0]        identifier;
  } translation_t;

  // Shadow copy of the table
  logic                table_valid      [ROWS];
  logic [ADDR_W-1:0]   table_address    [ROWS];
  logic [SECURE_W-1:0] table_secure     [ROWS];
  logic [ID_W-1:0]     table_identifier [ROWS];

  translation_t expected_translations[$];
  int unsigned  mismatches;

  // Applies one command to the shadow table and returns the result it should give
  function automatic translation_t translate(cmd_e cmd, logic [ADDR_W-1:0] address_key,
                                             logic [SECURE_W-1:0] secure_key,
                                             logic [ID_W-1:0] identifier);
    translation_t        res;
    logic [ADDR_W-1:0]   addr;
    logic [SECURE_W-1:0] sec;
    logic [ID_W-1:0]     ident;
    int                  found;
    int                  free_row;
    res      = '0;
    addr     = address_key & ADDR_MASK;
    sec      = secure_key & SECURE_MASK;
    ident    = identifier & ID_MASK;
    found    = -1;
    free_row = -1;
    case (cmd)
      CMD_REGISTER: begin
        // every row takes part, valid or not; the lowest row that matches by either key wins
        for (int i = 0; i < ROWS; i++) begin
          if (table_address[i] == addr || table_secure[i] == sec) begin
            found = i;
            break;
          end
          if (!table_valid[i] && free_row < 0) free_row = i;
        end
        if (found < 0) found = free_row;
        if (found >= 0) begin
          table_valid[found]      = 1'b1;
          table_address[found]    = addr;
          table_secure[found]     = sec;
          table_identifier[found] = ident;
        end
      end
      CMD_UNREGISTER, CMD_LOOKUP_ADDR: begin
        for (int i = 0; i < ROWS; i++) begin
          if (table_valid[i] && table_address[i] == addr) begin
            found = i;
            break;
          end
        end
        if (found >= 0) begin
          if (cmd == CMD_UNREGISTER) begin
            table_valid[found] = 1'b0;
          end else begin
            res.secure     = table_secure[found];
            res.identifier = table_identifier[found];
          end
        end
      end
      default: begin
        for (int i = 0; i < ROWS; i++) begin
          if (table_valid[i] && table_secure[i] == sec) begin
            found = i;
            break;
          end
        end
        if (found >= 0) res.address = table_address[found];
      end
    endcase
    if (found >= 0) begin
      res.hit     = 1'b1;
      res.row_num = found[ROW_INDEX_W-1:0];
    end
    return res;
  endfunction

  task automatic compare_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
      mismatches++;
    end
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    translation_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) begin
        table_valid[i]      = 1'b0;
        table_address[i]    = '0;
        table_secure[i]     = '0;
        table_identifier[i] = '0;
      end
      expected_translations.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      // result transfer
      if (done_i === 1'b1) begin
        if (expected_translations.size() == 0) begin
          $display("%0t: result with nothing expected, hit %b row %0d", $time, hit_i,
                   row_num_i);
          mismatches++;
        end else begin
          want = expected_translations.pop_front();
          compare_field("hit", 64'(want.hit), 64'(hit_i));
          compare_field("row_num", 64'(want.row_num), 64'(row_num_i));
          compare_field("address_out", 64'(want.address), 64'(address_out_i));
          compare_field("secure_out", want.secure, secure_out_i);
          compare_field("identifier_out", want.identifier, identifier_out_i);
        end
      end else if (done_i !== 1'b0) begin
        $display("%0t: done strobe unknown, expected 0, actual %b", $time, done_i);
        mismatches++;
      end
      // command transfer
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        expected_translations.push_back(translate(cmd_e'(cmd_i), address_key_i,
                                                  secure_key_i, identifier_in_i));
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= expected_translations.size();
    end
  end

endmodule

@@ dv/dual_key_address_translation_table_test.sv @@
// Stimulus and verdict for the dual-key address translation table.
module dual_key_address_translation_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dkat_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned POOL_SIZE    = 32;
  localparam int unsigned RANDOM_ITEMS = 170;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [1:0]             cmd_i = '0;
  logic [ADDR_W-1:0]      address_key_i = '0;
  logic [SECURE_W-1:0]    secure_key_i = '0;
  logic [ID_W-1:0]        identifier_in_i = '0;
  logic                   done_o;
  logic                   hit_o;
  logic [ROW_INDEX_W-1:0] row_num_o;
  logic [ADDR_W-1:0]      address_out_o;
  logic [SECURE_W-1:0]    secure_out_o;
  logic [ID_W-1:0]        identifier_out_o;
  int unsigned            mismatch_count;
  int unsigned            outstanding;
  int unsigned            cycle_count;

  // Stimulus controls and key pools shared across phases
  int unsigned         idle_pct;
  int unsigned         key_span;
  logic [ADDR_W-1:0]   address_pool [POOL_SIZE];
  logic [SECURE_W-1:0] secure_pool  [POOL_SIZE];

  dual_key_address_translation_table uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .address_key_i    (address_key_i),
    .secure_key_i     (secure_key_i),
    .identifier_in_i  (identifier_in_i),
    .done_o           (done_o),
    .hit_o            (hit_o),
    .row_num_o        (row_num_o),
    .address_out_o    (address_out_o),
    .secure_out_o     (secure_out_o),
    .identifier_out_o (identifier_out_o)
  );

  dual_key_address_translation_table_checker translation_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .cmd_i            (cmd_i),
    .address_key_i    (address_key_i),
    .secure_key_i     (secure_key_i),
    .identifier_in_i  (identifier_in_i),
    .done_i           (done_o),
    .hit_i            (hit_o),
    .row_num_i        (row_num_o),
    .address_out_i    (address_out_o),
    .secure_out_i     (secure_out_o),
    .identifier_out_i (identifier_out_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly pool keys so that rows get hit again; now and then a fresh key
  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 7) == 0) return ADDR_W'(random_word());
    return address_pool[$urandom_range(0, key_span - 1)];
  endfunction

  function automatic logic [SECURE_W-1:0] pick_secure();
    if ($urandom_range(0, 7) == 0) return random_word();
    return secure_pool[$urandom_range(0, key_span - 1)];
  endfunction

  // Present one command and hold it until the block takes the transfer
  task automatic issue(cmd_e cmd, logic [ADDR_W-1:0] address_key,
                       logic [SECURE_W-1:0] secure_key, logic [ID_W-1:0] identifier);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    cmd_i           <= cmd;
    address_key_i   <= address_key;
    secure_key_i    <= secure_key;
    identifier_in_i <= identifier;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Hold off the sender until every expected result is in
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic random_command();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) issue(CMD_REGISTER, pick_address(), pick_secure(), random_word());
    else if (pick < 60) issue(CMD_UNREGISTER, pick_address(), random_word(), random_word());
    else if (pick < 80) issue(CMD_LOOKUP_ADDR, pick_address(), random_word(), random_word());
    else issue(CMD_LOOKUP_SEC, ADDR_W'(random_word()), pick_secure(), random_word());
  endtask

  // Fresh keys overflow the table, so the last registers find it full
  task automatic fill_table();
    logic [ADDR_W-1:0]   addr;
    logic [SECURE_W-1:0] sec;
    for (int i = 0; i < ROWS_DEFAULT + 2; i++) begin
      addr = ADDR_W'(random_word());
      sec  = random_word();
      address_pool[i % POOL_SIZE] = addr;
      secure_pool[i % POOL_SIZE]  = sec;
      issue(CMD_REGISTER, addr, sec, random_word());
    end
  endtask

  // Run watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("dual_key_address_translation_table_test failed");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0]   a1;
    logic [ADDR_W-1:0]   a2;
    logic [ADDR_W-1:0]   a3;
    logic [SECURE_W-1:0] s1;
    logic [SECURE_W-1:0] s2;
    logic [SECURE_W-1:0] s3;
    logic [SECURE_W-1:0] s4;
    logic [SECURE_W-1:0] s5;
    int unsigned         phase_idle [4];
    int unsigned         phase_span [4];
    phase_idle = '{0, 54, 14, 0};
    phase_span = '{32, 6, 32, 12};
    idle_pct   = 0;
    key_span   = POOL_SIZE;
    for (int i = 0; i < POOL_SIZE; i++) begin
      address_pool[i] = ADDR_W'(random_word());
      secure_pool[i]  = random_word();
    end
    address_pool[0] = '0;
    secure_pool[0]  = '0;
    address_pool[1] = '1;
    secure_pool[1]  = '1;
    a1 = ADDR_W'(random_word()) | 1;
    a2 = ADDR_W'(random_word()) | 1;
    a3 = ADDR_W'(random_word()) | 1;
    s1 = random_word() | 1;
    s2 = random_word() | 1;
    s3 = random_word() | 1;
    s4 = random_word() | 1;
    s5 = random_word() | 1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table misses, extremes, overwrite by either key, stale rows
    issue(CMD_LOOKUP_ADDR, '0, '0, '0);
    issue(CMD_LOOKUP_SEC, '0, '0, '0);
    issue(CMD_UNREGISTER, '0, '0, '0);
    issue(CMD_REGISTER, a1, s1, random_word());
    issue(CMD_REGISTER, '1, '1, '1);
    issue(CMD_LOOKUP_ADDR, '1, '0, '0);
    issue(CMD_LOOKUP_SEC, '0, '1, '0);
    issue(CMD_REGISTER, '0, s2, random_word());    // lands on a zero invalid row
    issue(CMD_REGISTER, a1, s3, random_word());    // overwrite by address
    issue(CMD_REGISTER, a2, '1, random_word());    // overwrite by secure key
    issue(CMD_LOOKUP_SEC, '1, s3, '1);
    issue(CMD_UNREGISTER, a1, '1, '1);
    issue(CMD_LOOKUP_ADDR, a1, '0, '0);
    issue(CMD_UNREGISTER, a1, '0, '0);             // already invalid
    issue(CMD_REGISTER, a1, s4, random_word());    // stale row matches by address
    issue(CMD_REGISTER, a3, s5, random_word());    // first invalid row
    drain();

    // Random phases with different sender gaps and key spreads
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      key_span = phase_span[p];
      if (p == 2) begin
        // remove the rows that the first fill left behind
        for (int i = 0; i < POOL_SIZE; i++) issue(CMD_UNREGISTER, address_pool[i], '0, '0);
      end
      if (p == 0 || p == 2) begin
        fill_table();
        drain();
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) random_command();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("dual_key_address_translation_table_test passed");
    end else begin
      $display("dual_key_address_translation_table_test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dkat_pkg.sv
rtl/dkat_front.sv
rtl/dkat_back.sv
rtl/dual_key_address_translation_table.sv
rtl/dkat_checker.sv
dv/dual_key_address_translation_table_checker.sv
dv/dual_key_address_translation_table_test.sv
